@@ rtl/rfc_pkg.sv @@
package rfc_pkg;

  // Field and result widths
  localparam int unsigned DistW  = 32;
  localparam int unsigned ChargeW = 32;
  localparam int unsigned CoeffW = 48;
  localparam int unsigned ResW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  // Reciprocal pipeline: floor(2^RecipP / den), one quotient bit per stage
  localparam int unsigned RecipNW = 64;
  localparam int unsigned RecipP  = 96;

  // Bracket widths (signed, 48 fractional bits)
  localparam int unsigned TeW = 76;
  localparam int unsigned TfW = 67;

  localparam logic [ResW-1:0] SatMax = {1'b0, {(ResW-1){1'b1}}};
  localparam logic [ResW-1:0] SatMin = {1'b1, {(ResW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_CUTOFF  = 3'd0,
    REG_ESHIFT  = 3'd1,
    REG_FSHIFT  = 3'd2,
    REG_RFCOEFF = 3'd3,
    REG_KSCALE  = 3'd4
  } cfg_reg_e;

  // Per-item values carried alongside the reciprocal pipelines
  typedef struct packed {
    logic                  zero;
    logic                  qkneg;
    logic [63:0]           qk;
    logic signed [TeW-1:0] te;
    logic signed [TfW-1:0] tf;
  } side_t;

endpackage

@@ rtl/rfc_recip.sv @@
module rfc_recip import rfc_pkg::*; #(
  parameter int unsigned NW = RecipNW,
  parameter int unsigned P  = RecipP
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] den_i,
  output logic [P:0]    quo_o
);

  logic [NW-1:0] den_q [P];
  logic [NW-1:0] rem_q [P];
  logic [P:0]    quo_q [P+1];

  // restoring division of 2^P, one quotient bit per stage
  for (genvar k = 0; k <= P; k++) begin : g_step
    logic [NW-1:0] den_in;
    logic [NW-1:0] rem_in;
    logic [P:0]    quo_in;
    logic [NW:0]   sh;
    logic          take;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sh   = {rem_in, 1'(k == 0)};
    assign take = sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_in[P-1:0], take};
      end
    end

    if (k < P) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= den_in;
          rem_q[k] <= take ? NW'(sh - {1'b0, den_in}) : sh[NW-1:0];
        end
      end
    end
  end

  assign quo_o = quo_q[P];

endmodule

@@ rtl/reaction_field_coulomb_pair.sv @@
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: pair_distance, charge_product
// m_axis    out  m_axis_tvalid/tready       tdata: pair_energy, pair_force; tuser: zero_distance
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item per cycle while m_axis does not stall the pipe.
// Most of the pipe depth is the two reciprocal pipelines (one quotient bit per stage, 97 stages each).
// Reset clears the valid chain and the setup registers; datapath regs are not reset.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
// The cfg channel is always ready.
module reaction_field_coulomb_pair import rfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // [31:0] pair_distance, [63:32] charge_product
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [127:0]        m_axis_tdata,   // [63:0] pair_energy, [127:64] pair_force
  output logic                m_axis_tuser,   // [0] zero_distance
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned StgSide = 6;
  localparam int unsigned StgDiv  = 2 + RecipP + 1;
  localparam int unsigned StgOut  = StgDiv + 7;
  localparam int unsigned SideN   = StgDiv - StgSide + 1;

  typedef struct packed {
    logic        zero;
    logic        qkneg;
    logic [63:0] qk;
  } carry_t;

  typedef struct packed {
    logic zero;
    logic qkneg;
  } aux_t;

  // setup registers
  logic [31:0]        cutoff_q, eshift_q, fshift_q, kscale_q;
  logic [CoeffW-1:0]  rfc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
      eshift_q <= '0;
      fshift_q <= '0;
      rfc_q    <= '0;
      kscale_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CUTOFF:  cutoff_q <= cfg_data_i[31:0];
        REG_ESHIFT:  eshift_q <= cfg_data_i[31:0];
        REG_FSHIFT:  fshift_q <= cfg_data_i[31:0];
        REG_RFCOEFF: rfc_q    <= cfg_data_i;
        REG_KSCALE:  kscale_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic              cneg;
  logic [CoeffW-1:0] cmag;
  assign cneg = rfc_q[CoeffW-1];
  assign cmag = cneg ? (~rfc_q + CoeffW'(1)) : rfc_q;

  // global advance: whole pipe moves when the output slot is free or taken
  logic              en;
  logic [StgOut:1]   v_q;
  assign en            = ~v_q[StgOut] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[StgOut-1:1], s_axis_tvalid};
    end
  end

  // stage 1: sign split, d = cutoff - r
  logic [31:0] in_r, in_q, in_qmag;
  logic        in_dneg;
  logic [31:0] r1_q, qmag1_q, dmag1_q;
  logic        qneg1_q, dneg1_q;

  assign in_r    = s_axis_tdata[31:0];
  assign in_q    = s_axis_tdata[63:32];
  assign in_qmag = in_q[31] ? (~in_q + 32'd1) : in_q;
  assign in_dneg = cutoff_q < in_r;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q    <= in_r;
      qneg1_q <= in_q[31];
      qmag1_q <= in_qmag;
      dneg1_q <= in_dneg;
      dmag1_q <= in_dneg ? (in_r - cutoff_q) : (cutoff_q - in_r);
    end
  end

  // stage 2: 32x32 and 16x32 products
  carry_t      c2_q;
  logic        dneg2_q;
  logic [31:0] r2_q;
  logic [63:0] d2_2_q, rr2_q, rfs2_q, cdlo2_q;
  logic [47:0] cdhi2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q.qk    <= 64'(qmag1_q * kscale_q);
      c2_q.qkneg <= qneg1_q && (kscale_q != '0);
      c2_q.zero  <= (r1_q == '0);
      dneg2_q    <= dneg1_q;
      r2_q       <= r1_q;
      d2_2_q     <= 64'(dmag1_q * dmag1_q);
      rr2_q      <= 64'(r1_q * r1_q);
      rfs2_q     <= 64'(r1_q * fshift_q);
      cdlo2_q    <= 64'(cmag[31:0] * dmag1_q);
      cdhi2_q    <= 48'(cmag[47:32] * dmag1_q);
    end
  end

  // stage 3: C*d assembled, C*d^2 partial products
  carry_t      c3_q;
  logic        cdneg3_q;
  logic [63:0] rfs3_q;
  logic [79:0] cd3_q;
  logic [63:0] pp00_q, pp01_q;
  logic [47:0] pp10_q, pp11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q     <= c2_q;
      cdneg3_q <= cneg ^ dneg2_q;
      rfs3_q   <= rfs2_q;
      cd3_q    <= {16'b0, cdlo2_q} + {cdhi2_q, 32'b0};
      pp00_q   <= 64'(cmag[31:0] * d2_2_q[31:0]);
      pp01_q   <= 64'(cmag[31:0] * d2_2_q[63:32]);
      pp10_q   <= 48'(cmag[47:32] * d2_2_q[31:0]);
      pp11_q   <= 48'(cmag[47:32] * d2_2_q[63:32]);
    end
  end

  // stage 4: force bracket tail, C*d^2 row sums
  carry_t                c4_q;
  logic [63:0]           rfs4_q;
  logic signed [TfW-1:0] tf4_q;
  logic [95:0]           row_lo4_q;
  logic [79:0]           row_hi4_q;
  logic signed [TfW-1:0] tf_term;

  assign tf_term = $signed({2'b0, cd3_q[79:15]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q      <= c3_q;
      rfs4_q    <= rfs3_q;
      tf4_q     <= (cdneg3_q ? -tf_term : tf_term) - $signed({11'b0, fshift_q, 24'b0});
      row_lo4_q <= {32'b0, pp00_q} + {pp01_q, 32'b0};
      row_hi4_q <= {32'b0, pp10_q} + {pp11_q, 32'b0};
    end
  end

  // stage 5: C*d^2
  carry_t                c5_q;
  logic [63:0]           rfs5_q;
  logic signed [TfW-1:0] tf5_q;
  logic [111:0]          cd2_5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q    <= c4_q;
      rfs5_q  <= rfs4_q;
      tf5_q   <= tf4_q;
      cd2_5_q <= {16'b0, row_lo4_q} + {row_hi4_q, 32'b0};
    end
  end

  // stage 6 .. StgDiv: energy bracket tail, then wait for the reciprocals
  logic signed [TeW-1:0] te_term, te6;
  side_t                 side_q [SideN];

  assign te_term = $signed({4'b0, cd2_5_q[111:40]});
  assign te6 = (cneg ? -te_term : te_term) + $signed({12'b0, rfs5_q})
             - $signed({19'b0, eshift_q, 25'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{zero: c5_q.zero, qkneg: c5_q.qkneg, qk: c5_q.qk, te: te6, tf: tf5_q};
      for (int unsigned i = 1; i < SideN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // 1/r as 2^96 / (r * 2^24), 1/r^2 as 2^96 / r^2
  logic [RecipP:0] quo_a, quo_b;

  rfc_recip #(.NW(RecipNW), .P(RecipP)) u_recip_r (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i ({8'b0, r2_q, 24'b0}),
    .quo_o (quo_a)
  );

  rfc_recip #(.NW(RecipNW), .P(RecipP)) u_recip_r2 (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (rr2_q),
    .quo_o (quo_b)
  );

  side_t side_end;
  assign side_end = side_q[SideN-1];

  // StgDiv+1: brackets
  logic signed [TeW-1:0] e_q;
  logic signed [99:0]    f_q;
  logic [63:0]           qk100_q, qk101_q;
  aux_t                  aux_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q        <= $signed({3'b0, quo_a[72:0]}) + side_end.te;
      f_q        <= $signed({3'b0, quo_b}) + $signed({{33{side_end.tf[TfW-1]}}, side_end.tf});
      qk100_q    <= side_end.qk;
      qk101_q    <= qk100_q;
      aux_q[0]   <= '{zero: side_end.zero, qkneg: side_end.qkneg};
      for (int unsigned i = 1; i < 6; i++) begin
        aux_q[i] <= aux_q[i-1];
      end
    end
  end

  // StgDiv+2: magnitudes and result signs (0 energy, 1 force)
  logic [127:0] mag_q [2];
  logic         neg_q [2];
  logic         neg2_q [2], neg3_q [2], neg4_q [2], neg5_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= {52'b0, e_q[TeW-1] ? (~e_q + TeW'(1)) : e_q};
      mag_q[1] <= {28'b0, f_q[99] ? (~f_q + 100'd1) : f_q};
      neg_q[0] <= e_q[TeW-1] ^ aux_q[0].qkneg;
      neg_q[1] <= f_q[99] ^ aux_q[0].qkneg;
      neg2_q   <= neg_q;
      neg3_q   <= neg2_q;
      neg4_q   <= neg3_q;
      neg5_q   <= neg4_q;
    end
  end

  // StgDiv+3 .. StgDiv+6: bracket * qK in 32x32 partial products
  logic [63:0]  pp_q   [2][4][2];
  logic [95:0]  row_q  [2][4];
  logic [127:0] lo_q   [2];
  logic [127:0] hi_q   [2];
  logic [191:0] prod_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned j = 0; j < 2; j++) begin
        for (int unsigned i = 0; i < 4; i++) begin
          for (int unsigned h = 0; h < 2; h++) begin
            pp_q[j][i][h] <= 64'(mag_q[j][32*i +: 32] * qk101_q[32*h +: 32]);
          end
          row_q[j][i] <= {32'b0, pp_q[j][i][0]} + {pp_q[j][i][1], 32'b0};
        end
        lo_q[j]   <= {32'b0, row_q[j][0]} + {row_q[j][1], 32'b0};
        hi_q[j]   <= {32'b0, row_q[j][2]} + {row_q[j][3], 32'b0};
        prod_q[j] <= {64'b0, lo_q[j]} + {hi_q[j], 64'b0};
      end
    end
  end

  // >> 56 with magnitude truncation, then saturate
  function automatic logic [ResW-1:0] sat_out(input logic [191:0] p, input logic neg);
    logic [63:0] m;
    logic        big;
    m   = p[119:56];
    big = |p[191:120];
    if (neg) begin
      if (big || m > SatMin) return SatMin;
      return ~m + 64'd1;
    end
    if (big || m > SatMax) return SatMax;
    return m;
  endfunction

  logic [ResW-1:0] energy_q, force_q;
  logic            zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= aux_q[5].zero;
      if (aux_q[5].zero) begin
        energy_q <= aux_q[5].qkneg ? SatMin : SatMax;
        force_q  <= aux_q[5].qkneg ? SatMin : SatMax;
      end else begin
        energy_q <= sat_out(prod_q[0], neg5_q[0]);
        force_q  <= sat_out(prod_q[1], neg5_q[1]);
      end
    end
  end

  assign m_axis_tvalid = v_q[StgOut];
  assign m_axis_tdata  = {force_q, energy_q};
  assign m_axis_tuser  = zero_q;

  // zero distance always reports a matched saturated pair
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (energy_q == force_q) && ((energy_q == SatMax) || (energy_q == SatMin)))
    else $error("zero-distance result not saturated");

  // a held pipe keeps its valid bits
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid chain moved during stall");

  // 1/r fits 73 bits; anything above means the reciprocal and side paths are misaligned
  a_recip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StgDiv] && !side_end.zero |-> quo_a[RecipP:73] == '0)
    else $error("1/r quotient out of range");

endmodule
